[hw/rtl/assert_macros.svh]
// Assertion macros for the breakpoint table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LBT_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lbt_pkg.sv]
// Types and codes of the line breakpoint table.
package lbt_pkg;

   localparam int ACT_W       = 3;
   localparam int LINE_W      = 16;
   localparam int SET_COUNT_W = 5;

   localparam logic [ACT_W-1:0] ACT_TOGGLE = 3'd0;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

   typedef logic [SET_COUNT_W-1:0] count_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [LINE_W-1:0] line;
      logic [LINE_W-1:0] line_count;
      logic [LINE_W-1:0] text_lines;
   } req_payload_type;

   typedef struct packed {
      logic      is_set;
      logic      table_full;
      count_type set_count;
   } rsp_payload_type;

   typedef struct packed {
      logic      idle;
      logic      done;
      logic      is_set;
      logic      table_full;
      count_type set_count;
   } eng_status_type;

endpackage

[hw/rtl/lbt_channels.sv]
// Request and response channel interfaces of the line breakpoint table.
interface lbt_req_if;
   logic                     valid;
   logic                     ready;
   lbt_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lbt_rsp_if;
   logic                     valid;
   logic                     ready;
   lbt_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/lbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lbt_engine.sv]
// Sequencer that sweeps the slot memory for the toggle, query, delete and insert actions.
module lbt_engine #(
   parameter int MAX_BREAKS = 16,
   parameter int LINE_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lbt_pkg::req_payload_type cmd,
   input  logic                     take,
   output lbt_pkg::eng_status_type  stat
);

   localparam int IDX_W  = (MAX_BREAKS > 1) ? $clog2(MAX_BREAKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BREAKS + 1);
   localparam int WIDE_W = ((LINE_BITS > lbt_pkg::LINE_W) ? LINE_BITS : lbt_pkg::LINE_W) + 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_BREAKS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_COMMIT = 3'd2;
   localparam logic [2:0] S_ORD    = 3'd3;
   localparam logic [2:0] S_OEVAL  = 3'd4;
   localparam logic [2:0] S_ISCAN  = 3'd5;
   localparam logic [2:0] S_IEND   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [MAX_BREAKS-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        iss_ff, iss_in;
   logic                        chk_ff, chk_in;

   logic [lbt_pkg::ACT_W-1:0]   act_ff, act_in;
   logic [LINE_BITS-1:0]        lo_ff, lo_in;
   logic [LINE_BITS-1:0]        hi_ff, hi_in;
   logic [lbt_pkg::LINE_W-1:0]  lcnt_ff, lcnt_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]            oi_ff, oi_in;
   logic [LINE_BITS-1:0]        nv_ff, nv_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic                        free_ff, free_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [MAX_BREAKS-1:0]       mov_ff, mov_in;
   logic                        is_set_ff, is_set_in;
   logic                        full_ff, full_in;

   logic                        ram_we;
   logic [IDX_W-1:0]            ram_waddr;
   logic [LINE_BITS-1:0]        ram_wdata;
   logic [IDX_W-1:0]            ram_raddr;
   logic [LINE_BITS-1:0]        rd;

   logic                        ent_v;
   logic                        rng;
   logic                        in_rng;
   logic [WIDE_W-1:0]           up_w;
   logic                        up_over;
   logic [WIDE_W-1:0]           keep_w;
   logic [WIDE_W-1:0]           dn_w;
   logic                        dn_drop;
   logic                        nm;

   lbt_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_BREAKS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd)
   );

   assign ent_v   = valid_ff[chk_idx_ff];
   assign rng     = (rd >= lo_ff) && (rd <= hi_ff);
   assign in_rng  = ent_v && rng;
   assign up_w    = WIDE_W'(rd) + WIDE_W'(lcnt_ff);
   assign up_over = |up_w[WIDE_W-1:LINE_BITS];
   assign keep_w  = WIDE_W'(lo_ff) + WIDE_W'(lcnt_ff);
   assign dn_w    = WIDE_W'(rd) - WIDE_W'(lcnt_ff);
   assign dn_drop = (WIDE_W'(rd) < keep_w) || (WIDE_W'(rd) == WIDE_W'(lcnt_ff));

   always_comb begin
      if (chk_idx_ff == oi_ff) begin
         nm = 1'b0;
      end else if (chk_idx_ff < oi_ff) begin
         nm = !mov_ff[chk_idx_ff];
      end else begin
         nm = !in_rng;
      end
   end

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      iss_in      = iss_ff;
      chk_in      = 1'b0;
      act_in      = act_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      lcnt_in     = lcnt_ff;
      idx_in      = idx_ff;
      chk_idx_in  = chk_idx_ff;
      oi_in       = oi_ff;
      nv_in       = nv_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      mov_in      = mov_ff;
      is_set_in   = is_set_ff;
      full_in     = full_ff;
      ram_we      = 1'b0;
      ram_waddr   = chk_idx_ff;
      ram_wdata   = nv_ff;
      ram_raddr   = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = cmd.action;
               lo_in     = LINE_BITS'(cmd.line);
               hi_in     = LINE_BITS'(cmd.text_lines);
               lcnt_in   = cmd.line_count;
               is_set_in = 1'b0;
               full_in   = 1'b0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               idx_in    = '0;
               iss_in    = 1'b1;
               oi_in     = '0;
               unique case (cmd.action) inside
                  lbt_pkg::ACT_TOGGLE, lbt_pkg::ACT_QUERY: begin
                     state_in = (LINE_BITS'(cmd.line) == '0) ? S_DONE : S_SCAN;
                  end
                  lbt_pkg::ACT_DELETE: begin
                     state_in = S_SCAN;
                  end
                  lbt_pkg::ACT_INSERT: begin
                     state_in = S_ORD;
                  end
                  lbt_pkg::ACT_CLEAR: begin
                     valid_in = '0;
                     cnt_in   = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (iss_ff) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff;
               if (idx_ff == LAST) begin
                  iss_in = 1'b0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (chk_ff) begin
               if (act_ff == lbt_pkg::ACT_DELETE) begin
                  if (in_rng) begin
                     if (dn_drop) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        cnt_in               = cnt_ff - CNT_W'(1);
                     end else begin
                        ram_we    = 1'b1;
                        ram_wdata = dn_w[LINE_BITS-1:0];
                     end
                  end
               end else begin
                  if (ent_v && (rd == lo_ff)) begin
                     hit_in     = 1'b1;
                     hit_idx_in = chk_idx_ff;
                  end
                  if (!ent_v && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end
               if (chk_idx_ff == LAST) begin
                  state_in = (act_ff == lbt_pkg::ACT_DELETE) ? S_DONE : S_COMMIT;
               end
            end
         end

         S_COMMIT: begin
            if (act_ff == lbt_pkg::ACT_QUERY) begin
               is_set_in = hit_ff;
            end else if (hit_ff) begin
               valid_in[hit_idx_ff] = 1'b0;
               cnt_in               = cnt_ff - CNT_W'(1);
            end else if (free_ff) begin
               ram_we                = 1'b1;
               ram_waddr             = free_idx_ff;
               ram_wdata             = lo_ff;
               valid_in[free_idx_ff] = 1'b1;
               cnt_in                = cnt_ff + CNT_W'(1);
               is_set_in             = 1'b1;
            end else begin
               full_in = 1'b1;
            end
            state_in = S_DONE;
         end

         S_ORD: begin
            ram_raddr  = oi_ff;
            chk_idx_in = oi_ff;
            state_in   = S_OEVAL;
         end

         S_OEVAL: begin
            mov_in[chk_idx_ff] = in_rng;
            if (in_rng && !up_over) begin
               nv_in    = up_w[LINE_BITS-1:0];
               hit_in   = 1'b0;
               idx_in   = '0;
               iss_in   = 1'b1;
               state_in = S_ISCAN;
            end else begin
               if (in_rng) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  cnt_in               = cnt_ff - CNT_W'(1);
               end
               if (oi_ff == LAST) begin
                  state_in = S_DONE;
               end else begin
                  oi_in    = oi_ff + IDX_W'(1);
                  state_in = S_ORD;
               end
            end
         end

         S_ISCAN: begin
            if (iss_ff) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff;
               if (idx_ff == LAST) begin
                  iss_in = 1'b0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (chk_ff) begin
               if (nm && ent_v && (rd == nv_ff)) begin
                  hit_in = 1'b1;
               end
               if (chk_idx_ff == LAST) begin
                  state_in = S_IEND;
               end
            end
         end

         S_IEND: begin
            if (hit_ff) begin
               valid_in[oi_ff] = 1'b0;
               cnt_in          = cnt_ff - CNT_W'(1);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = oi_ff;
               ram_wdata = nv_ff;
            end
            if (oi_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               oi_in    = oi_ff + IDX_W'(1);
               state_in = S_ORD;
            end
         end

         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         cnt_ff   <= '0;
         iss_ff   <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         iss_ff   <= iss_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      lcnt_ff     <= lcnt_in;
      idx_ff      <= idx_in;
      chk_idx_ff  <= chk_idx_in;
      oi_ff       <= oi_in;
      nv_ff       <= nv_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      mov_ff      <= mov_in;
      is_set_ff   <= is_set_in;
      full_ff     <= full_in;
   end

   assign stat.idle       = (state_ff == S_IDLE);
   assign stat.done       = (state_ff == S_DONE);
   assign stat.is_set     = is_set_ff;
   assign stat.table_full = full_ff;
   assign stat.set_count  = lbt_pkg::count_type'(cnt_ff);

endmodule

[hw/rtl/line_breakpoint_table.sv]
// Top level of the line breakpoint table: handshake, response register, checks.
//
//  channel   dir  word                                        ports
//  req       in   action, line, line_count, text_lines        req_chan
//  rsp       out  is_set, table_full, set_count               rsp_chan
//
// Clear-all, unknown actions, toggle/query of line zero: no pass over memory.
// Toggle, query, delete: one pass over the slot memory.
// Insert: reads each slot; a shifted slot adds a scan (one memory read port).
// Reset clears the slot valid bits and the count.
// A new word is taken once the previous result sits in the response register;
// a stalled response holds the engine in its final state.
`include "assert_macros.svh"

module line_breakpoint_table #(
   parameter int MAX_BREAKS = 16,
   parameter int LINE_BITS  = 16
) (
   input logic       clock,
   input logic       reset,
   lbt_req_if.sink   req_chan,
   lbt_rsp_if.source rsp_chan
);

   lbt_pkg::eng_status_type  stat;
   logic                     start;
   logic                     take;
   logic                     rsp_valid_ff, rsp_valid_in;
   lbt_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   assign req_chan.ready = stat.idle;
   assign start          = req_chan.valid && stat.idle;
   assign take           = stat.done && (!rsp_valid_ff || rsp_chan.ready);

   lbt_engine #(
      .MAX_BREAKS (MAX_BREAKS),
      .LINE_BITS  (LINE_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_chan.payload),
      .take  (take),
      .stat  (stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.is_set     = stat.is_set;
         rsp_data_in.table_full = stat.table_full;
         rsp_data_in.set_count  = stat.set_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `LBT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "engine still idle after taking a word")

   `LBT_ASSERT_NEXT(a_take_loads_rsp, clock, reset, take, rsp_chan.valid, "finished result not loaded into response register")

   `LBT_ASSERT_HOLDS(a_full_means_full, clock, reset, rsp_chan.valid && rsp_chan.payload.table_full, !rsp_chan.payload.is_set && (rsp_chan.payload.set_count == lbt_pkg::count_type'(MAX_BREAKS)), "table full reported with free slots left")

endmodule
